// File: rtl/core/sspg_pkg.sv
// Shared types and constants for the step/direction pulse generator.
// No dependencies; imported by the controller, the datapath and the top level.
package sspg_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_SPEED = 2'd1,
    REQ_POS   = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  localparam logic [1:0] CFG_MAX_SPEED   = 2'd0;
  localparam logic [1:0] CFG_MICRO_STEP  = 2'd1;
  localparam logic [1:0] CFG_REVERSE_DIR = 2'd2;

  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [22:0] MAX_SPEED_RST  = 23'h7FFFFF;
  localparam logic [5:0]  MICRO_STEP_RST = 6'd16;
  localparam logic [31:0] IDLE_PERIOD    = 32'd100000;

  typedef struct packed {
    req_e               req_type;
    logic signed [23:0] speed_value;
    logic signed [31:0] position_value;
  } in_word_t;

  typedef struct packed {
    logic               step_out;
    logic               dir_out;
    logic signed [31:0] position;
    logic               running;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic tick;
    logic pos_load;
    logic speed_load;
    logic scale;
    logic decide;
    logic div_step;
    logic out_load;
  } sspg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic changed;
    logic scaled_zero;
    logic div_last;
  } sspg_sts_t;

endpackage

// File: rtl/core/stepper_step_pulse_generator.sv
// Step/direction pulse generator. Tick, position and no-op words: one word per
// cycle while idle with output room, result registered in the cycle after acceptance.
// Speed words: scale, decide, then the restoring period divider (one quotient bit per
// cycle, 32 bits) unless the speed is unchanged or scales to zero; input stalls until
// the result loads. Reset (rst_ni low, asynchronous) clears the timer, position and
// result valid and restores the configuration defaults; no clearing pass is needed.
module stepper_step_pulse_generator #(
  parameter int unsigned PERIOD_NUMERATOR = 400000
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sspg_pkg::in_word_t              in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sspg_pkg::out_word_t             out_word_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [sspg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sspg_pkg::*;

  sspg_cmd_t cmd;
  sspg_sts_t sts;

  assign cfg_ready_o = 1'b1;

  sspg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_word_i.req_type),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sspg_dpath #(
    .PERIOD_NUMERATOR (PERIOD_NUMERATOR)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_word_o  (out_word_o)
  );

endmodule

// File: rtl/core/sspg_ctrl.sv
// Controller state machine for the step/direction pulse generator.
// Sequences speed words through scale, decide and divide; uses sspg_pkg.
module sspg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  sspg_pkg::req_e    in_req_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sspg_pkg::sspg_cmd_t cmd_o,
  input  sspg_pkg::sspg_sts_t sts_i
);
  import sspg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_DECIDE,
    S_DIV,
    S_PUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_room;
  logic   in_fire;

  assign out_room   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_room;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_req_i)
            REQ_TICK: begin
              cmd_o.tick     = 1'b1;
              cmd_o.out_load = 1'b1;
            end
            REQ_POS: begin
              cmd_o.pos_load = 1'b1;
              cmd_o.out_load = 1'b1;
            end
            REQ_SPEED: begin
              cmd_o.speed_load = 1'b1;
              state_d          = S_SCALE;
            end
            default: cmd_o.out_load = 1'b1;
          endcase
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = (sts_i.changed && !sts_i.scaled_zero) ? S_DIV : S_PUT;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_PUT;
      end
      S_PUT: begin
        // wait for room in the output register
        if (out_room) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_load_has_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> out_room)
    else $error("result loaded over a held word");

  a_speed_to_scale : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_req_i == REQ_SPEED) |=> state_q == S_SCALE)
    else $error("speed word did not start scaling");

  a_div_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !sts_i.div_last) |=> state_q == S_DIV)
    else $error("divider left early");

  a_valid_from_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.out_load))
    else $error("result valid without a load");

endmodule

// File: rtl/core/sspg_dpath.sv
// Datapath for the step/direction pulse generator: step timer, position,
// speed scaling, 1-bit-per-cycle period divider and result register. Uses sspg_pkg.
module sspg_dpath #(
  parameter int unsigned PERIOD_NUMERATOR = 400000
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sspg_pkg::in_word_t    in_word_i,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [sspg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  sspg_pkg::sspg_cmd_t   cmd_i,
  output sspg_pkg::sspg_sts_t   sts_o,
  output sspg_pkg::out_word_t   out_word_o
);
  import sspg_pkg::*;

  localparam logic [31:0] Dividend = {PERIOD_NUMERATOR[23:0], 8'h00};

  // configuration
  logic [22:0] max_speed_q;
  logic [5:0]  micro_step_q;
  logic        reverse_dir_q;

  // architectural state
  logic        step_level_q, step_level_d;
  logic [31:0] position_q, position_d;
  logic        dir_rev_q, dir_rev_d;
  logic [23:0] prev_speed_q, prev_speed_d;
  logic [31:0] period_q, period_d;
  logic [31:0] count_q, count_d;
  logic        timer_on_q, timer_on_d;

  // speed path
  logic [23:0] raw_speed;
  logic        speed_neg;
  logic [23:0] mag_q;
  logic        changed_q;
  logic [29:0] product;
  logic [25:0] prod_scaled;
  logic [22:0] scaled_q;

  // divider
  logic [22:0] rem_q;
  logic [31:0] quot_q;
  logic [4:0]  div_cnt_q;
  logic [23:0] trial;
  logic        trial_ge;
  logic [22:0] rem_next;
  logic [31:0] quot_next;

  logic [31:0] count_inc;
  out_word_t   out_word_q;

  assign raw_speed   = in_word_i.speed_value;
  assign speed_neg   = raw_speed[23];
  assign product     = 30'(mag_q) * 30'(micro_step_q);
  assign prod_scaled = product[29:4];

  assign trial     = {rem_q, quot_q[31]};
  assign trial_ge  = trial >= {1'b0, scaled_q};
  assign rem_next  = trial_ge ? 23'(trial - {1'b0, scaled_q}) : trial[22:0];
  assign quot_next = {quot_q[30:0], trial_ge};

  assign sts_o.changed     = changed_q;
  assign sts_o.scaled_zero = (scaled_q == '0);
  assign sts_o.div_last    = (div_cnt_q == '1);

  assign count_inc = count_q + 32'd1;

  always_comb begin
    step_level_d = step_level_q;
    position_d   = position_q;
    dir_rev_d    = dir_rev_q;
    prev_speed_d = prev_speed_q;
    period_d     = period_q;
    count_d      = count_q;
    timer_on_d   = timer_on_q;

    if (cmd_i.tick && timer_on_q) begin
      // period zero wraps to the compare always passing, like a period of one
      if (count_inc >= period_q) begin
        count_d = '0;
        if (!step_level_q) begin
          position_d   = position_q + (dir_rev_q ? 32'hFFFF_FFFF : 32'd1);
          step_level_d = 1'b1;
        end else begin
          step_level_d = 1'b0;
        end
      end else begin
        count_d = count_inc;
      end
    end
    if (cmd_i.pos_load) position_d = in_word_i.position_value;
    if (cmd_i.speed_load) begin
      dir_rev_d    = speed_neg || (raw_speed == '0);
      prev_speed_d = raw_speed;
    end
    if (cmd_i.decide && changed_q && scaled_q == '0) begin
      period_d   = IDLE_PERIOD;
      timer_on_d = 1'b0;
    end
    if (cmd_i.div_step && sts_o.div_last) begin
      period_d   = quot_next;
      timer_on_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q   <= MAX_SPEED_RST;
      micro_step_q  <= MICRO_STEP_RST;
      reverse_dir_q <= 1'b0;
      step_level_q  <= 1'b0;
      position_q    <= '0;
      dir_rev_q     <= 1'b0;
      prev_speed_q  <= '0;
      period_q      <= IDLE_PERIOD;
      count_q       <= '0;
      timer_on_q    <= 1'b0;
      changed_q     <= 1'b0;
      div_cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MAX_SPEED:   max_speed_q   <= cfg_data_i[22:0];
          CFG_MICRO_STEP:  micro_step_q  <= cfg_data_i[5:0];
          CFG_REVERSE_DIR: reverse_dir_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      step_level_q <= step_level_d;
      position_q   <= position_d;
      dir_rev_q    <= dir_rev_d;
      prev_speed_q <= prev_speed_d;
      period_q     <= period_d;
      count_q      <= count_d;
      timer_on_q   <= timer_on_d;
      if (cmd_i.speed_load) changed_q <= (prev_speed_q != raw_speed);
      if (cmd_i.decide) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.speed_load) mag_q <= speed_neg ? 24'(~raw_speed + 24'd1) : raw_speed;
    if (cmd_i.scale) begin
      // clip to max_speed
      scaled_q <= (prod_scaled > {3'b000, max_speed_q}) ? max_speed_q : prod_scaled[22:0];
    end
    if (cmd_i.decide) begin
      rem_q  <= '0;
      quot_q <= Dividend;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_next;
      quot_q <= quot_next;
    end
    if (cmd_i.out_load) begin
      out_word_q.step_out <= step_level_d;
      out_word_q.dir_out  <= dir_rev_d ^ reverse_dir_q;
      out_word_q.position <= position_d;
      out_word_q.running  <= timer_on_d;
    end
  end

  assign out_word_o = out_word_q;

endmodule

// File: tb/tb_top.sv
// Self-checking bench for stepper_step_pulse_generator: tick, speed, position and idle
// words under random input gaps and output stalls, checked against an in-bench model.
// Depends on sspg_pkg and the top level only.
module tb_top;
  import sspg_pkg::*;

  localparam int unsigned PERIOD_NUM = 400000;
  localparam logic [1:0]  CFG_SPARE  = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  in_word_t         in_word_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_word_t        out_word_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  stepper_step_pulse_generator #(
    .PERIOD_NUMERATOR(PERIOD_NUM)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Register copies and pulse generator state of the model
  logic [22:0] reg_max_speed  = MAX_SPEED_RST;
  logic [5:0]  reg_micro_step = MICRO_STEP_RST;
  logic        reg_reverse    = 1'b0;

  logic        sim_level      = 1'b0;
  logic [31:0] sim_pos        = '0;
  logic        sim_dir_rev    = 1'b0;
  logic [23:0] sim_prev_speed = '0;
  logic [31:0] sim_period     = IDLE_PERIOD;
  logic [31:0] sim_count      = '0;
  logic        sim_running    = 1'b0;

  in_word_t  pending_words[$];
  out_word_t expected_state[$];
  logic [23:0] gen_last_speed = '0;

  logic idle_on = 1'b1;
  int   gap_left = 0;
  int   stall_left = 0;
  int   words_sent = 0;
  int   results_seen = 0;
  int   mismatches = 0;
  int   step_pulses = 0;
  int   settings_run = 1;
  int   kind_count[4] = '{0, 0, 0, 0};

  // Advance the pulse generator by one word and return the pin state after it.
  function automatic out_word_t step_generator_model(in_word_t w);
    out_word_t   r;
    logic [31:0] next_count;
    logic [23:0] raw;
    logic [24:0] mag;
    logic [63:0] scaled;
    logic [63:0] quot;
    case (w.req_type)
      REQ_TICK: begin
        if (sim_running) begin
          next_count = sim_count + 32'd1;
          if (next_count >= sim_period) begin
            sim_count = '0;
            if (!sim_level) begin
              sim_pos = sim_dir_rev ? sim_pos - 32'd1 : sim_pos + 32'd1;
              sim_level = 1'b1;
              step_pulses++;
            end else begin
              sim_level = 1'b0;
            end
          end else begin
            sim_count = next_count;
          end
        end
      end
      REQ_SPEED: begin
        raw = w.speed_value;
        // zero counts as reverse, the most negative value has magnitude 2^23
        if (raw != '0 && !raw[23]) begin
          sim_dir_rev = 1'b0;
          mag = {1'b0, raw};
        end else begin
          sim_dir_rev = 1'b1;
          mag = (raw == '0) ? '0 : 25'h100_0000 - {1'b0, raw};
        end
        scaled = (64'(mag) * 64'(reg_micro_step)) >> 4;
        if (scaled > 64'(reg_max_speed)) scaled = 64'(reg_max_speed);
        // period and timer move only when the raw speed changes
        if (sim_prev_speed != raw) begin
          if (scaled != '0) begin
            quot = (64'(PERIOD_NUM) * 64'd256) / scaled;
            sim_period = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
            sim_running = 1'b1;
          end else begin
            sim_period = IDLE_PERIOD;
            sim_running = 1'b0;
          end
        end
        sim_prev_speed = raw;
      end
      REQ_POS: sim_pos = w.position_value;
      default: ;
    endcase
    r.step_out = sim_level;
    r.dir_out  = sim_dir_rev ^ reg_reverse;
    r.position = sim_pos;
    r.running  = sim_running;
    return r;
  endfunction

  function automatic int draw_idle();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Driver: present queued words, hold a stalled word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_state.push_back(step_generator_model(in_word_i));
        kind_count[in_word_i.req_type]++;
        words_sent++;
        if (words_sent % 128 == 0) idle_on <= ($urandom_range(0, 3) != 0);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_words.size() > 0) begin
          in_word_i <= pending_words.pop_front();
          in_valid_i <= 1'b1;
          gap_left <= draw_idle();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_result(out_word_t got);
    out_word_t want;
    if (expected_state.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result word step %0b dir %0b pos %0d run %0b",
                 $time, got.step_out, got.dir_out, got.position, got.running);
      return;
    end
    want = expected_state.pop_front();
    results_seen++;
    if (got.step_out !== want.step_out || got.dir_out !== want.dir_out ||
        got.position !== want.position || got.running !== want.running) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch step %0b/%0b dir %0b/%0b pos %0d/%0d run %0b/%0b (exp/got)",
                 $time, want.step_out, got.step_out, want.dir_out, got.dir_out,
                 want.position, got.position, want.running, got.running);
    end
  endtask

  // Monitor: take result words, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      int hold;
      if (out_valid_o && !out_stall_i) check_result(out_word_o);
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        hold = draw_idle();
        out_stall_i <= (hold != 0);
        stall_left <= (hold > 0) ? hold - 1 : 0;
      end
    end
  end

  function automatic in_word_t rand_word(req_e kind);
    in_word_t w;
    w.req_type       = kind;
    w.speed_value    = 24'($urandom);
    w.position_value = $urandom;
    return w;
  endfunction

  task automatic push_word(in_word_t w);
    if (w.req_type == REQ_SPEED) gen_last_speed = w.speed_value;
    pending_words.push_back(w);
  endtask

  task automatic push_speed(logic [23:0] v);
    in_word_t w;
    w = rand_word(REQ_SPEED);
    w.speed_value = v;
    push_word(w);
  endtask

  task automatic push_position(logic [31:0] v);
    in_word_t w;
    w = rand_word(REQ_POS);
    w.position_value = v;
    push_word(w);
  endtask

  task automatic push_ticks(int n);
    repeat (n) push_word(rand_word(REQ_TICK));
  endtask

  function automatic logic [31:0] pick_position();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a speed word followed by a run of ticks, the rest loose noise.
  task automatic push_random_traffic(int n);
    int          made;
    int          r;
    logic [23:0] mag24;
    logic [23:0] v;
    in_word_t    w;
    made = 1;
    // repeat the last speed first: registers changed, period must hold
    push_speed(gen_last_speed);
    while (made < n) begin
      if ($urandom_range(0, 99) < 75) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          v = gen_last_speed;
        end else if (r < 4) begin
          v = 24'($urandom);
        end else if (r == 4) begin
          mag24 = 24'($urandom_range(0, 20));
          v = $urandom_range(0, 1) ? mag24 : -mag24;
        end else begin
          mag24 = 24'($urandom_range(4194304, 8388608));
          v = $urandom_range(0, 1) ? mag24 : -mag24;
        end
        push_speed(v);
        made++;
        repeat ($urandom_range(8, 60)) begin
          if ($urandom_range(0, 29) == 0) push_position(pick_position());
          else push_ticks(1);
          made++;
        end
      end else begin
        w = rand_word(req_e'($urandom_range(0, 3)));
        if (w.req_type == REQ_POS) w.position_value = pick_position();
        push_word(w);
        if (w.req_type != REQ_NONE) made++;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid_i || expected_state.size() != 0)
      @(negedge clk_i);
  endtask

  // Write one register; junk above the field width must be ignored.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    logic [31:0] data;
    data = $urandom;
    case (idx)
      CFG_MAX_SPEED:   data[22:0] = value[22:0];
      CFG_MICRO_STEP:  data[5:0]  = value[5:0];
      CFG_REVERSE_DIR: data[0]    = value[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MAX_SPEED:   reg_max_speed  = data[22:0];
      CFG_MICRO_STEP:  reg_micro_step = data[5:0];
      CFG_REVERSE_DIR: reg_reverse    = data[0];
      default: ;
    endcase
  endtask

  task automatic run_setting(logic [22:0] max_speed, logic [5:0] micro_step,
                             logic reverse, int n);
    wait_drained();
    write_reg(CFG_MAX_SPEED, 32'(max_speed));
    write_reg(CFG_MICRO_STEP, 32'(micro_step));
    write_reg(CFG_REVERSE_DIR, 32'(reverse));
    settings_run++;
    push_random_traffic(n);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at reset settings
    push_word(rand_word(REQ_TICK));
    push_word(rand_word(REQ_NONE));
    push_position(32'h7FFF_FFFF);
    push_speed(24'h7F_FFFF);
    push_ticks(12);
    push_speed(24'h80_0000);
    push_speed(24'h80_0000);
    push_speed(24'h00_0000);
    push_word(rand_word(REQ_TICK));
    push_speed(24'd15);
    push_speed(24'd1);
    push_position(32'h8000_0000);
    push_speed(24'hFF_FFFF);
    push_position(32'h0000_0000);

    run_setting(23'h7F_FFFF, 6'd63, 1'b1, 300);
    wait_drained();
    write_reg(CFG_SPARE, $urandom);
    run_setting(23'($urandom), 6'd1, 1'b0, 200);
    run_setting(23'h7F_FFFF, 6'd0, 1'b1, 60);
    run_setting(23'h00_0000, 6'd32, 1'b0, 60);
    run_setting(23'($urandom_range(1000000, 8388607)), 6'($urandom_range(1, 63)),
                1'($urandom), 300);
    run_setting(23'h7F_FFFF, 6'd16, 1'b0, 330);

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Run covered %0d words (%0d tick, %0d speed, %0d position, %0d idle) over %0d settings",
             words_sent, kind_count[REQ_TICK], kind_count[REQ_SPEED], kind_count[REQ_POS],
             kind_count[REQ_NONE], settings_run);
    $display("%0d results checked, %0d step pulses, %0d mismatches",
             results_seen, step_pulses, mismatches);
    if (mismatches == 0 && expected_state.size() == 0) begin
      $display("stepper_step_pulse_generator regression: pass");
    end else begin
      $display("stepper_step_pulse_generator regression: fail");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Timed out with %0d results outstanding", expected_state.size());
    $display("stepper_step_pulse_generator regression: fail");
    $finish;
  end

endmodule
